FILE: hdl/tet_pkg.sv
// Shared types, constants and the operation sequence of the tetrahedron barycentric core.
package tet_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int WEIGHT_FRAC = 16;
	localparam int OPF_DEPTH = 19;
	localparam int OPF_AW = 5;
	localparam int UOP_COUNT = 30;

	localparam logic [OPF_AW-1:0] IDX_DEN = 5'd15;
	localparam logic [OPF_AW-1:0] IDX_NB1 = 5'd16;
	localparam logic [4:0] UOP_LAST = 5'(UOP_COUNT - 1);
	localparam logic [3:0] PREP_LAST = 4'd11;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_RD,
		ST_MLD,
		ST_MUL,
		ST_WB,
		ST_DRD,
		ST_DLD,
		ST_DIV,
		ST_OUT
	} state_t;

	// One multiply step: operand slots, target slot and accumulator control.
	typedef struct packed {
		logic [OPF_AW-1:0] a;
		logic [OPF_AW-1:0] b;
		logic [OPF_AW-1:0] dest;
		logic              first;
		logic              last;
		logic              neg;
	} uop_t;

	// Slots: 0..2 edge 1, 3..5 edge 2, 6..8 edge 3, 9..11 point offset,
	// 12..14 cross product, 15 volume term, 16..18 partial volumes.
	function automatic uop_t uop_rom(input logic [4:0] idx);
		uop_t u;
		unique case (idx)
			5'd0:  u = '{5'd4,  5'd8,  5'd0,  1'b1, 1'b0, 1'b0};
			5'd1:  u = '{5'd5,  5'd7,  5'd12, 1'b0, 1'b1, 1'b1};
			5'd2:  u = '{5'd5,  5'd6,  5'd0,  1'b1, 1'b0, 1'b0};
			5'd3:  u = '{5'd3,  5'd8,  5'd13, 1'b0, 1'b1, 1'b1};
			5'd4:  u = '{5'd3,  5'd7,  5'd0,  1'b1, 1'b0, 1'b0};
			5'd5:  u = '{5'd4,  5'd6,  5'd14, 1'b0, 1'b1, 1'b1};
			5'd6:  u = '{5'd0,  5'd12, 5'd0,  1'b1, 1'b0, 1'b0};
			5'd7:  u = '{5'd1,  5'd13, 5'd0,  1'b0, 1'b0, 1'b0};
			5'd8:  u = '{5'd2,  5'd14, 5'd15, 1'b0, 1'b1, 1'b0};
			5'd9:  u = '{5'd9,  5'd12, 5'd0,  1'b1, 1'b0, 1'b0};
			5'd10: u = '{5'd10, 5'd13, 5'd0,  1'b0, 1'b0, 1'b0};
			5'd11: u = '{5'd11, 5'd14, 5'd16, 1'b0, 1'b1, 1'b0};
			5'd12: u = '{5'd10, 5'd8,  5'd0,  1'b1, 1'b0, 1'b0};
			5'd13: u = '{5'd11, 5'd7,  5'd12, 1'b0, 1'b1, 1'b1};
			5'd14: u = '{5'd11, 5'd6,  5'd0,  1'b1, 1'b0, 1'b0};
			5'd15: u = '{5'd9,  5'd8,  5'd13, 1'b0, 1'b1, 1'b1};
			5'd16: u = '{5'd9,  5'd7,  5'd0,  1'b1, 1'b0, 1'b0};
			5'd17: u = '{5'd10, 5'd6,  5'd14, 1'b0, 1'b1, 1'b1};
			5'd18: u = '{5'd0,  5'd12, 5'd0,  1'b1, 1'b0, 1'b0};
			5'd19: u = '{5'd1,  5'd13, 5'd0,  1'b0, 1'b0, 1'b0};
			5'd20: u = '{5'd2,  5'd14, 5'd17, 1'b0, 1'b1, 1'b0};
			5'd21: u = '{5'd4,  5'd11, 5'd0,  1'b1, 1'b0, 1'b0};
			5'd22: u = '{5'd5,  5'd10, 5'd12, 1'b0, 1'b1, 1'b1};
			5'd23: u = '{5'd5,  5'd9,  5'd0,  1'b1, 1'b0, 1'b0};
			5'd24: u = '{5'd3,  5'd11, 5'd13, 1'b0, 1'b1, 1'b1};
			5'd25: u = '{5'd3,  5'd10, 5'd0,  1'b1, 1'b0, 1'b0};
			5'd26: u = '{5'd4,  5'd9,  5'd14, 1'b0, 1'b1, 1'b1};
			5'd27: u = '{5'd0,  5'd12, 5'd0,  1'b1, 1'b0, 1'b0};
			5'd28: u = '{5'd1,  5'd13, 5'd0,  1'b0, 1'b0, 1'b0};
			5'd29: u = '{5'd2,  5'd14, 5'd18, 1'b0, 1'b1, 1'b0};
			default: u = '{5'd0, 5'd0, 5'd0, 1'b1, 1'b0, 1'b0};
		endcase
		return u;
	endfunction

endpackage

FILE: hdl/tet_opf.sv
// Operand memory holding edge vectors and intermediate products.
module tet_opf import tet_pkg::*; #(
	parameter int W = 80
) (
	input  logic              clk,
	input  logic              we,
	input  logic [OPF_AW-1:0] wa,
	input  logic [W-1:0]      wd,
	input  logic [OPF_AW-1:0] ra,
	input  logic [OPF_AW-1:0] rb,
	output logic [W-1:0]      qa,
	output logic [W-1:0]      qb
);

	logic [W-1:0] mem_q [OPF_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		qa <= mem_q[ra];
		qb <= mem_q[rb];
	end

endmodule

FILE: hdl/tet_smul.sv
// Bit-serial multiply-accumulate unit, one multiplier bit per cycle.
module tet_smul import tet_pkg::*; #(
	parameter int W = 80
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic         clr,
	input  logic         neg,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         busy,
	output logic [W-1:0] acc
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  acc_q;

	// The product is formed modulo 2^W; every value of the sequence fits in W bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= neg ? (~a + 1'b1) : a;
			b_q <= b;
			if (clr) begin
				acc_q <= '0;
			end
		end else if (cnt_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[W-2:0], 1'b0};
			b_q <= {1'b0, b_q[W-1:1]};
		end
	end

	assign busy = (cnt_q != '0);
	assign acc = acc_q;

endmodule

FILE: hdl/tet_sdiv.sv
// Restoring divider, one quotient bit per cycle, with rounding and saturation.
module tet_sdiv import tet_pkg::*; #(
	parameter int W = 80
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         busy,
	output logic [31:0]  quo
);

	localparam int NW = W + WEIGHT_FRAC;
	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [W-1:0]  md_q;
	logic [W-1:0]  rem_q;
	logic [32:0]   q_q;
	logic          ovf_q;
	logic          neg_q;

	logic [W-1:0]  mn;
	logic [W-1:0]  md;
	logic [W:0]    rem_sh;
	logic          qbit;
	logic [W:0]    rem_diff;
	logic [32:0]   lim;
	logic [32:0]   mag;

	always_comb begin
		mn = num[W-1] ? (~num + 1'b1) : num;
		md = den[W-1] ? (~den + 1'b1) : den;
		rem_sh = {rem_q, num_q[NW-1]};
		rem_diff = rem_sh - {1'b0, md_q};
		qbit = (rem_sh >= {1'b0, md_q});
		lim = neg_q ? 33'h080000000 : 33'h07FFFFFFF;
		mag = (ovf_q || (q_q > lim)) ? lim : q_q;
		quo = neg_q ? (~mag[31:0] + 1'b1) : mag[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Magnitudes are divided; half the divisor is added first to round to nearest.
	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= num[W-1] ^ den[W-1];
			num_q <= {mn, {WEIGHT_FRAC{1'b0}}} + {{(WEIGHT_FRAC + 1){1'b0}}, md[W-1:1]};
			md_q  <= md;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= qbit ? rem_diff[W-1:0] : rem_sh[W-1:0];
			q_q   <= {q_q[31:0], qbit};
			ovf_q <= ovf_q | q_q[32];
		end
	end

	assign busy = (cnt_q != '0);

endmodule

FILE: hdl/tetrahedron_barycentric_core.sv
// Top level: vertex storage, operation sequencer and result registers.
// A vertex load word is stored when accepted and gives no result.
// A query runs the bit-serial multiplier (30 products), W = 3*COORD_BITS+8, and then the
// bit-serial divider (4 quotients), which is skipped when the volume term is zero.
// One query is in flight at a time; busy stays high until the result strobe has passed.
// Reset clears the vertex store to zero and returns the sequencer to idle.
module tetrahedron_barycentric_core import tet_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  action,
	input  logic [1:0]            vertex_index,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [COORD_BITS-1:0] pos_z,
	output logic                  done,
	output logic [31:0]           weight_first,
	output logic [31:0]           weight_second,
	output logic [31:0]           weight_third,
	output logic [31:0]           weight_fourth,
	output logic                  inside_res,
	output logic                  degenerate
);

	localparam int W = 3 * COORD_BITS + 8;
	localparam int DW = COORD_BITS + 1;

	state_t state_q, state_d;

	logic [COORD_BITS-1:0] vs_q [12];
	logic [COORD_BITS-1:0] pos_q [3];
	logic [3:0]            pc_q;
	logic [4:0]            uidx_q;
	logic [1:0]            k_q;
	logic [W-1:0]          den_q;
	logic [W-1:0]          nu_q;
	logic [31:0]           w_q [4];
	logic                  degen_q;

	logic [DW-1:0]         dif [12];
	uop_t                  uop;
	logic                  accept;

	logic                  opf_we;
	logic [OPF_AW-1:0]     opf_wa;
	logic [W-1:0]          opf_wd;
	logic [OPF_AW-1:0]     opf_ra;
	logic [OPF_AW-1:0]     opf_rb;
	logic [W-1:0]          opf_qa;
	logic [W-1:0]          opf_qb;

	logic                  mul_load;
	logic                  mul_busy;
	logic [W-1:0]          mul_acc;
	logic                  div_load;
	logic                  div_busy;
	logic [31:0]           div_quo;
	logic [W-1:0]          div_num;

	assign accept = start && !busy;
	assign uop = uop_rom(uidx_q);

	// Edge vectors from vertex 0 and the point offset, all formed side by side.
	always_comb begin
		for (int j = 0; j < 12; j++) begin
			if (j < 9) begin
				dif[j] = {vs_q[j + 3][COORD_BITS-1], vs_q[j + 3]}
					- {vs_q[j % 3][COORD_BITS-1], vs_q[j % 3]};
			end else begin
				dif[j] = {pos_q[j - 9][COORD_BITS-1], pos_q[j - 9]}
					- {vs_q[j % 3][COORD_BITS-1], vs_q[j % 3]};
			end
		end
	end

	tet_opf #(.W(W)) u_opf (
		.clk (clk),
		.we  (opf_we),
		.wa  (opf_wa),
		.wd  (opf_wd),
		.ra  (opf_ra),
		.rb  (opf_rb),
		.qa  (opf_qa),
		.qb  (opf_qb)
	);

	tet_smul #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (mul_load),
		.clr    (uop.first),
		.neg    (uop.neg),
		.a      (opf_qa),
		.b      (opf_qb),
		.busy   (mul_busy),
		.acc    (mul_acc)
	);

	assign div_num = (k_q == 2'd0) ? nu_q : opf_qa;

	tet_sdiv #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (div_load),
		.num    (div_num),
		.den    (den_q),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && action) state_d = ST_PREP;
			ST_PREP: if (pc_q == PREP_LAST) state_d = ST_RD;
			ST_RD:   state_d = ST_MLD;
			ST_MLD:  state_d = ST_MUL;
			ST_MUL:  if (!mul_busy) state_d = ST_WB;
			ST_WB: begin
				if (uidx_q == UOP_LAST) begin
					state_d = (den_q == '0) ? ST_OUT : ST_DRD;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_DRD:  state_d = ST_DLD;
			ST_DLD:  state_d = ST_DIV;
			ST_DIV:  if (!div_busy) state_d = (k_q == 2'd3) ? ST_OUT : ST_DRD;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q != ST_IDLE);
		done     = (state_q == ST_OUT);
		mul_load = (state_q == ST_MLD);
		div_load = (state_q == ST_DLD);
		opf_we   = 1'b0;
		opf_wa   = uop.dest;
		opf_wd   = mul_acc;
		opf_ra   = uop.a;
		opf_rb   = uop.b;
		unique case (state_q)
			ST_PREP: begin
				opf_we = 1'b1;
				opf_wa = OPF_AW'(pc_q);
				opf_wd = {{(W - DW){dif[pc_q][DW-1]}}, dif[pc_q]};
			end
			ST_WB: opf_we = uop.last;
			ST_DRD: opf_ra = IDX_DEN + OPF_AW'(k_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			uidx_q  <= '0;
			k_q     <= '0;
			for (int j = 0; j < 12; j++) begin
				vs_q[j] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept && !action) begin
				for (int j = 0; j < 12; j++) begin
					if (2'(j / 3) == vertex_index) begin
						vs_q[j] <= (j % 3 == 0) ? pos_x : ((j % 3 == 1) ? pos_y : pos_z);
					end
				end
			end
			if (accept) begin
				pc_q   <= '0;
				uidx_q <= '0;
				k_q    <= '0;
			end
			if (state_q == ST_PREP) begin
				pc_q <= pc_q + 1'b1;
			end
			if (state_q == ST_WB && uidx_q != UOP_LAST) begin
				uidx_q <= uidx_q + 1'b1;
			end
			if (state_q == ST_DIV && !div_busy) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// The weight of vertex 0 takes the volume term less the three partial volumes.
	always_ff @(posedge clk) begin
		if (accept && action) begin
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
			for (int j = 0; j < 4; j++) begin
				w_q[j] <= '0;
			end
		end
		if (state_q == ST_WB && uop.last) begin
			if (uop.dest == IDX_DEN) begin
				den_q <= mul_acc;
				nu_q  <= mul_acc;
			end else if (uop.dest >= IDX_NB1) begin
				nu_q <= nu_q - mul_acc;
			end
		end
		if (state_q == ST_WB && uidx_q == UOP_LAST) begin
			degen_q <= (den_q == '0);
		end
		if (state_q == ST_DIV && !div_busy) begin
			w_q[k_q] <= div_quo;
		end
	end

	always_comb begin
		weight_first  = w_q[0];
		weight_second = w_q[1];
		weight_third  = w_q[2];
		weight_fourth = w_q[3];
		degenerate    = degen_q;
		inside_res    = !degen_q;
		for (int j = 0; j < 4; j++) begin
			if (w_q[j][31] || ($signed(w_q[j]) > $signed(32'h00010000))) begin
				inside_res = 1'b0;
			end
		end
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result word shown while the core reads as idle");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("result strobe not a single cycle followed by idle");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action |=> busy && !done)
		else $error("query word did not start the sequencer");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> weight_first == 32'h0 && weight_fourth == 32'h0 && !inside_res)
		else $error("degenerate result carries nonzero weights");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy && div_busy))
		else $error("multiplier and divider active together");

endmodule
